@@ design/button_click_long_press_detector_defines.svh @@
// assertion macros for the button click and long-press detector
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define BCLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bclp check failed");

// next-cycle implication, checked on i_clk outside reset
`define BCLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bclp check failed");

`endif

@@ design/bclp_pkg.sv @@
// shared types and constants of the button click and long-press detector
package bclp_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CODE_W    = 3;
    localparam int unsigned COUNT_W   = 8;

    // event codes
    localparam logic [CODE_W-1:0] EV_NONE   = 3'd0;
    localparam logic [CODE_W-1:0] EV_SINGLE = 3'd1;
    localparam logic [CODE_W-1:0] EV_DOUBLE = 3'd2;
    localparam logic [CODE_W-1:0] EV_TRIPLE = 3'd3;
    localparam logic [CODE_W-1:0] EV_LONG   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP  = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd300;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] click_gap_ms;
    } t_cfg;

endpackage

@@ design/bclp_ifs.sv @@
// handshake channel interfaces: scan input, event output, register writes
interface bclp_in_if;
    import bclp_pkg::*;
    logic              valid;
    logic              ready;
    logic              key_down;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, key_down, now_ms, input ready);
    modport sink   (input valid, key_down, now_ms, output ready);
endinterface

interface bclp_out_if;
    import bclp_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    modport source (output valid, event_code, input ready);
    modport sink   (input valid, event_code, output ready);
endinterface

interface bclp_cfg_if;
    import bclp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bclp_cfg_regs.sv @@
// configuration register file: long-press, debounce and click-gap times
module bclp_cfg_regs
    import bclp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    bclp_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register update, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms <= LONG_PRESS_RST;
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
            r_cfg.click_gap_ms  <= CLICK_GAP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg.data;
                REG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg.data;
                REG_CLICK_GAP:  r_cfg.click_gap_ms  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ design/bclp_core.sv @@
// key tracking state and the per-scan event decision
module bclp_core
    import bclp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_key_down,
    input  logic [TIME_W-1:0] i_now_ms,
    input  t_cfg              i_cfg,
    output logic [CODE_W-1:0] o_event_code
);

    logic               r_is_down;
    logic               r_long_reported;
    logic [TIME_W-1:0]  r_press_time;
    logic [TIME_W-1:0]  r_release_time;
    logic [COUNT_W-1:0] r_click_count;

    logic               n_is_down;
    logic               n_long_reported;
    logic [TIME_W-1:0]  n_press_time;
    logic [TIME_W-1:0]  n_release_time;
    logic [COUNT_W-1:0] n_click_count;

    logic [TIME_W-1:0]  held;
    logic [TIME_W-1:0]  gap;
    logic [TIME_W-1:0]  long_lim;
    logic [TIME_W-1:0]  deb_lim;
    logic [TIME_W-1:0]  gap_lim;
    logic [CODE_W-1:0]  code;

    assign long_lim = {{(TIME_W-CFG_W){1'b0}}, i_cfg.long_press_ms};
    assign deb_lim  = {{(TIME_W-CFG_W){1'b0}}, i_cfg.debounce_ms};
    assign gap_lim  = {{(TIME_W-CFG_W){1'b0}}, i_cfg.click_gap_ms};

    // wrapping hold time
    assign held = i_now_ms - r_press_time;

    // press, hold and release handling, then click sequence timeout
    always_comb begin
        n_is_down       = r_is_down;
        n_long_reported = r_long_reported;
        n_press_time    = r_press_time;
        n_release_time  = r_release_time;
        n_click_count   = r_click_count;
        code            = EV_NONE;

        if (i_key_down) begin
            if (!r_is_down) begin
                n_press_time = i_now_ms;
                n_is_down    = 1'b1;
            end else if (!r_long_reported && (held > long_lim)) begin
                code            = EV_LONG;
                n_long_reported = 1'b1;
            end
        end else if (r_is_down) begin
            if ((held <= long_lim) && (held > deb_lim)) begin
                if (r_click_count != COUNT_MAX) begin
                    n_click_count = r_click_count + 1'b1;
                end
                n_release_time = i_now_ms;
            end
            n_is_down       = 1'b0;
            n_long_reported = 1'b0;
        end

        gap = i_now_ms - n_release_time;
        if ((n_click_count != '0) && (gap > gap_lim)) begin
            if (n_click_count <= {{(COUNT_W-CODE_W){1'b0}}, EV_TRIPLE}) begin
                code = n_click_count[CODE_W-1:0];
            end
            n_click_count = '0;
        end
    end

    // state update, one scan per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_down       <= 1'b0;
            r_long_reported <= 1'b0;
            r_press_time    <= '0;
            r_release_time  <= '0;
            r_click_count   <= '0;
        end else if (i_en) begin
            r_is_down       <= n_is_down;
            r_long_reported <= n_long_reported;
            r_press_time    <= n_press_time;
            r_release_time  <= n_release_time;
            r_click_count   <= n_click_count;
        end
    end

    assign o_event_code = code;

endmodule

@@ design/button_click_long_press_detector.sv @@
// top level of the button click and long-press detector
//
//   port     direction  carries
//   i_in     sink       key_down, now_ms (one scan per item)
//   o_out    source     event_code (one result item per scan)
//   i_cfg    sink       index, data (register writes, always ready)
//
// a scan item is registered in the input register, and the event logic and the
// key state update then run into the result register; one item per cycle
// sustained while the result side does not stall.
// reset is synchronous and active low; it restores the register defaults.
// a stalled result holds the pipeline; the input register still fills if empty.
`include "button_click_long_press_detector_defines.svh"

module button_click_long_press_detector
    import bclp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bclp_in_if.sink     i_in,
    bclp_out_if.source  o_out,
    bclp_cfg_if.sink    i_cfg
);

    t_cfg              cfg;
    logic              r_in_vld;
    logic              r_key_down;
    logic [TIME_W-1:0] r_now_ms;
    logic              r_out_vld;
    logic [CODE_W-1:0] r_event_code;
    logic [CODE_W-1:0] core_code;
    logic              out_free;
    logic              advance;

    // pipeline flow control
    assign out_free   = !r_out_vld || o_out.ready;
    assign advance    = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;

    bclp_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bclp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_key_down   (r_key_down),
        .i_now_ms     (r_now_ms),
        .i_cfg        (cfg),
        .o_event_code (core_code)
    );

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_key_down <= i_in.key_down;
            r_now_ms   <= i_in.now_ms;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_event_code <= core_code;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.event_code = r_event_code;

    // checks
    `BCLP_ASSERT_NEXT(a_in_taken, i_in.valid && i_in.ready, r_in_vld)
    `BCLP_ASSERT_NEXT(a_advance_fills_out, advance, r_out_vld)
    `BCLP_ASSERT_NOW(a_code_in_range, r_out_vld, r_event_code <= EV_LONG)

endmodule

@@ tb/button_click_long_press_detector_checker.sv @@
// scoreboard for the button detector: predicts one event code per scan and checks results
module button_click_long_press_detector_checker
    import bclp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bclp_in_if   i_scan,
    bclp_out_if  i_event,
    bclp_cfg_if  i_wr,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 10;

    // predictor copy of the registers and key state
    t_cfg               regs;
    logic               key_held;
    logic               long_seen;
    logic [TIME_W-1:0]  press_ms;
    logic [TIME_W-1:0]  release_ms;
    logic [COUNT_W-1:0] clicks;

    logic [CODE_W-1:0]  expected_codes[$];
    int                 fail_total;

    // one scan through the predictor: updates the key state, returns the event code
    function automatic logic [CODE_W-1:0] predict_event(input logic key,
                                                        input logic [TIME_W-1:0] now);
        logic [CODE_W-1:0] code;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] quiet;
        code = EV_NONE;
        held = now - press_ms;
        if (key) begin
            if (!key_held) begin
                press_ms = now;
                key_held = 1'b1;
            end else if (!long_seen && held > TIME_W'(regs.long_press_ms)) begin
                code = EV_LONG;
                long_seen = 1'b1;
            end
        end else if (key_held) begin
            // only a press between debounce and long-press time counts as a click
            if (held <= TIME_W'(regs.long_press_ms) && held > TIME_W'(regs.debounce_ms)) begin
                if (clicks != COUNT_MAX)
                    clicks = clicks + 1'b1;
                release_ms = now;
            end
            key_held = 1'b0;
            long_seen = 1'b0;
        end
        // gap expiry ends the sequence; a click code wins over a long press
        quiet = now - release_ms;
        if (clicks != '0 && quiet > TIME_W'(regs.click_gap_ms)) begin
            if (clicks <= COUNT_W'(EV_TRIPLE))
                code = clicks[CODE_W-1:0];
            clicks = '0;
        end
        return code;
    endfunction

    always @(posedge i_clk) begin
        logic [CODE_W-1:0] want;
        if (!i_rst_n) begin
            regs.long_press_ms = LONG_PRESS_RST;
            regs.debounce_ms   = DEBOUNCE_RST;
            regs.click_gap_ms  = CLICK_GAP_RST;
            key_held   = 1'b0;
            long_seen  = 1'b0;
            press_ms   = '0;
            release_ms = '0;
            clicks     = '0;
            expected_codes.delete();
            fail_total = 0;
        end else begin
            // register writes
            if (i_wr.valid && i_wr.ready) begin
                case (i_wr.index)
                    REG_LONG_PRESS: regs.long_press_ms = i_wr.data;
                    REG_DEBOUNCE:   regs.debounce_ms   = i_wr.data;
                    REG_CLICK_GAP:  regs.click_gap_ms  = i_wr.data;
                    default:        ;
                endcase
            end
            // accepted scan item
            if (i_scan.valid && i_scan.ready)
                expected_codes.push_back(predict_event(i_scan.key_down, i_scan.now_ms));
            // accepted result item
            if (i_event.valid && i_event.ready) begin
                if (expected_codes.size() == 0) begin
                    if (fail_total < MAX_REPORTS)
                        $display("[%0t] unexpected event item, code %0d", $realtime,
                                 i_event.event_code);
                    fail_total++;
                end else begin
                    want = expected_codes.pop_front();
                    if (i_event.event_code !== want) begin
                        if (fail_total < MAX_REPORTS)
                            $display("[%0t] event_code mismatch: expected %0d, got %0d",
                                     $realtime, want, i_event.event_code);
                        fail_total++;
                    end
                end
            end
        end
        o_pending    = expected_codes.size();
        o_fail_count = fail_total;
    end

endmodule

@@ tb/button_click_long_press_detector_tb.sv @@
// testbench top for the button detector: clock, reset, scan stimulus, register writes, verdict
module button_click_long_press_detector_tb
    import bclp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 100;
    localparam int SAT_CLICKS      = 258;
    localparam int PHASE_ITEMS     = 36;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    int          src_idle_pct;
    int          snk_stall_pct;
    logic        hold_off;
    int          sent;
    logic [31:0] t_ms;
    logic [31:0] cfg_long;
    logic [31:0] cfg_deb;
    logic [31:0] cfg_gap;

    bclp_in_if  in_ch();
    bclp_out_if out_ch();
    bclp_cfg_if cfg_ch();

    button_click_long_press_detector u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    button_click_long_press_detector_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_scan       (in_ch),
        .i_event      (out_ch),
        .i_wr         (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(negedge i_clk) begin
        out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // offer one scan item, with random idle cycles ahead of it
    task automatic scan(input logic key, input logic [31:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.key_down <= key;
        in_ch.now_ms   <= stamp;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic set_idling(input int mode);
        @(posedge i_clk);
        case (mode)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
            default: begin src_idle_pct = 11; snk_stall_pct = 11; end
        endcase
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected item has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] lp, input logic [CFG_W-1:0] db,
                              input logic [CFG_W-1:0] gp, input bit poke_spare);
        drain();
        write_reg(REG_LONG_PRESS, lp);
        write_reg(REG_DEBOUNCE, db);
        write_reg(REG_CLICK_GAP, gp);
        // the unused index must leave every register alone
        if (poke_spare)
            write_reg(REG_SPARE, CFG_W'($urandom));
        cfg_ch.valid <= 1'b0;
        cfg_long = 32'(lp);
        cfg_deb  = 32'(db);
        cfg_gap  = 32'(gp);
    endtask

    // a value at or just off a threshold, or a random value up to just above it
    function automatic logic [31:0] near(input logic [31:0] mark);
        case ($urandom_range(3))
            0:       return mark - 1;
            1:       return mark;
            2:       return mark + 1;
            default: return $urandom_range(mark + 2);
        endcase
    endfunction

    function automatic logic [31:0] click_hold();
        if (cfg_long > cfg_deb && $urandom_range(2) != 0)
            return $urandom_range(cfg_long, cfg_deb + 1);
        return near($urandom_range(1) ? cfg_deb : cfg_long);
    endfunction

    task automatic click(input logic [31:0] hold);
        scan(1'b1, t_ms);
        if ($urandom_range(3) == 0)
            scan(1'b1, t_ms + hold / 2);
        t_ms += hold;
        scan(1'b0, t_ms);
    endtask

    task automatic click_burst();
        repeat ($urandom_range(5, 1)) begin
            t_ms += $urandom_range(cfg_gap / 2);
            click(click_hold());
        end
    endtask

    // one random episode: mostly well-formed press patterns, some noise
    task automatic random_episode();
        logic [31:0] ext;
        logic [31:0] press_at;
        case ($urandom_range(9))
            0, 1, 2: begin
                // click sequence closed around the gap boundary
                click_burst();
                scan(1'b0, t_ms + near(cfg_gap));
                t_ms += cfg_gap + 1;
                scan(1'b0, t_ms);
            end
            3: begin
                // long hold with a few scans past the threshold
                press_at = t_ms;
                scan(1'b1, press_at);
                t_ms = press_at + near(cfg_long);
                scan(1'b1, t_ms);
                repeat ($urandom_range(3)) begin
                    t_ms += $urandom_range(cfg_long / 4 + 1);
                    scan(1'b1, t_ms);
                end
                t_ms += $urandom_range(cfg_long / 2 + 1);
                scan(1'b0, t_ms);
            end
            4, 5: begin
                // gap runs out in the same scan that a new hold turns long
                click_burst();
                ext = (cfg_gap > cfg_long) ? cfg_gap : cfg_long;
                press_at = t_ms + 1;
                scan(1'b1, press_at);
                t_ms += ext + 2;
                scan(1'b1, t_ms);
                t_ms += 1;
                scan(1'b0, t_ms);
            end
            6: begin
                repeat ($urandom_range(4, 1)) begin
                    t_ms += $urandom_range(cfg_gap + 2);
                    scan(1'b0, t_ms);
                end
            end
            7: begin
                repeat ($urandom_range(3, 1)) begin
                    t_ms = $urandom;
                    scan(1'($urandom_range(1)), t_ms);
                end
            end
            8: begin
                // timestamp steps backwards
                t_ms -= $urandom_range(1000, 1);
                scan(1'($urandom_range(1)), t_ms);
            end
            default: begin
                t_ms += $urandom_range(cfg_gap / 2);
                click(click_hold());
            end
        endcase
    endtask

    task automatic random_items(input int count);
        int target;
        target = sent + count;
        while (sent < target)
            random_episode();
    endtask

    // more clicks than the counter holds, then one gap expiry
    task automatic saturate_count();
        repeat (SAT_CLICKS) begin
            t_ms += 1;
            scan(1'b1, t_ms);
            t_ms += 1;
            scan(1'b0, t_ms);
        end
        t_ms += 32'd65536;
        scan(1'b0, t_ms);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.key_down  = 1'b0;
        in_ch.now_ms    = '0;
        out_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = REG_LONG_PRESS;
        cfg_ch.data     = '0;
        hold_off        = 1'b0;
        src_idle_pct    = 0;
        snk_stall_pct   = 0;
        sent            = 0;
        t_ms            = '0;
        cfg_long        = 32'(LONG_PRESS_RST);
        cfg_deb         = 32'(DEBOUNCE_RST);
        cfg_gap         = 32'(CLICK_GAP_RST);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed scans on the reset settings
        scan(1'b0, 32'd1000);
        scan(1'b1, 32'd1000);               // press exactly at the debounce time: nothing
        scan(1'b0, 32'd1020);
        scan(1'b1, 32'd2000);               // single click, gap boundary
        scan(1'b0, 32'd2021);
        scan(1'b0, 32'd2321);
        scan(1'b0, 32'd2322);
        scan(1'b1, 32'd3000);               // double click
        scan(1'b0, 32'd3100);
        scan(1'b1, 32'd3200);
        scan(1'b0, 32'd3300);
        scan(1'b0, 32'd3601);
        scan(1'b1, 32'd4000);               // triple, first press held exactly long time
        scan(1'b0, 32'd5000);
        scan(1'b1, 32'd5100);
        scan(1'b0, 32'd5130);
        scan(1'b1, 32'd5200);
        scan(1'b0, 32'd5250);
        scan(1'b0, 32'd5551);
        scan(1'b1, 32'd6000);               // long press reported once, release counts no click
        scan(1'b1, 32'd7000);
        scan(1'b1, 32'd7001);
        scan(1'b1, 32'd9000);
        scan(1'b0, 32'd9001);
        scan(1'b1, 32'hFFFF_FFF0);          // click across the timestamp wrap
        scan(1'b0, 32'h0000_0010);
        scan(1'b0, 32'h0000_0200);
        scan(1'b1, 32'd50000);              // backwards timestamp reads as a very long hold
        scan(1'b1, 32'd40000);
        scan(1'b0, 32'd40001);
        t_ms = 32'd50000;
        random_items(PHASE_ITEMS);

        // phases over settings and idling patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(16'd0, 16'd0, 16'd0, 1'b0);
                1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                3: set_config(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
                default: begin
                    cfg_deb = $urandom_range(30);
                    set_config(CFG_W'(cfg_deb + $urandom_range(300, 5)), CFG_W'(cfg_deb),
                               CFG_W'($urandom_range(600, 10)), p == 2);
                end
            endcase
            set_idling(p % 4);
            if (p == 3)
                saturate_count();
            if (p == 4) begin
                fork
                    begin
                        @(posedge i_clk);
                        hold_off = 1'b1;
                        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_items(PHASE_ITEMS);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
